/* rtl/dccdp_pkg.sv */
package dccdp_pkg;

	localparam int TABLE_DEPTH = 2048;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int WORD_W      = 16;
	localparam int PHASE_W     = 32;
	localparam int FRAC_W      = 16;
	localparam int CNT_W       = 16;
	localparam int LIMIT_W     = 8;
	localparam int FIELD_ADDR_W = 11;
	localparam int OP_W        = 3;
	localparam int IN_DATA_W   = 32;
	localparam int IN_USER_W   = 4;
	localparam int OUT_DATA_W  = 56;
	localparam int APB_ADDR_W  = 4;
	localparam int APB_DATA_W  = 32;

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 3'd0,
		OP_WRITE  = 3'd1,
		OP_RUN    = 3'd2,
		OP_STOP   = 3'd3,
		OP_REWIND = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		REG_STEP_A       = 2'd0,
		REG_STEP_B       = 2'd1,
		REG_CYCLE_LIMIT  = 2'd2,
		REG_LIMIT_ENABLE = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [PHASE_W-1:0] step_a;
		logic [PHASE_W-1:0] step_b;
		logic [LIMIT_W-1:0] cycle_limit;
		logic               limit_enable;
	} cfg_t;

	typedef struct packed {
		logic tick;
		logic run;
		logic stop;
		logic rewind;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             running;
	} tick_res_t;

endpackage

/* rtl/dual_channel_dds_waveform_player.sv */
// An accepted tick reads both tables into s1, then passes on to the output register.
// Throughput: one request per cycle while s_axis_tready is high; table writes and
// ticks may interleave freely. A result waiting on m_axis does not stop intake until
// the stage behind it fills. Reset clears control state, then zeroes all 2048 entries
// of both tables, one per cycle, s_axis_tready low; APB writes are taken meanwhile.
module dual_channel_dds_waveform_player
	import dccdp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // table_address[10:0], table_word[26:11]
	input  logic [IN_USER_W-1:0]  s_axis_tuser,  // opcode[2:0], table_select[3]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // dac_a_word[15:0], dac_b_word[31:16],
	                                             // period_count[47:32], still_running[48]
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t                    cfg;
	cmd_t                    cmd;
	tick_res_t               res;
	tick_res_t               res_s1;
	logic                    valid_s1;
	logic                    fire;
	logic [ADDR_W-1:0]       idx_a, idx_b;
	logic [WORD_W-1:0]       rd_a, rd_b;
	logic                    clearing_q;
	logic [ADDR_W-1:0]       clr_q;
	logic                    in_ready;
	logic                    acc;
	opcode_t                 op;
	logic                    sel;
	logic [FIELD_ADDR_W-1:0] taddr;
	logic [WORD_W-1:0]       tword;
	logic                    wr_ok;
	logic                    we_a, we_b;
	logic [ADDR_W-1:0]       waddr;
	logic [WORD_W-1:0]       wdata;
	logic                    out_load;
	logic                    out_valid_q;
	logic [OUT_DATA_W-1:0]   out_data_q;

	assign pready = 1'b1;

	dccdp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign op    = opcode_t'(s_axis_tuser[OP_W-1:0]);
	assign sel   = s_axis_tuser[OP_W];
	assign taddr = s_axis_tdata[FIELD_ADDR_W-1:0];
	assign tword = s_axis_tdata[FIELD_ADDR_W +: WORD_W];

	assign in_ready      = !clearing_q && (!valid_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = in_ready;
	assign acc           = s_axis_tvalid && in_ready;

	always_comb begin
		cmd   = '0;
		wr_ok = 1'b0;
		if (acc) begin
			unique case (op)
				OP_TICK:   cmd.tick   = 1'b1;
				OP_WRITE:  wr_ok      = (32'(taddr) < TABLE_DEPTH);
				OP_RUN:    cmd.run    = 1'b1;
				OP_STOP:   cmd.stop   = 1'b1;
				OP_REWIND: cmd.rewind = 1'b1;
				default: ;
			endcase
		end
	end

	dccdp_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg),
		.fire   (fire),
		.idx_a  (idx_a),
		.idx_b  (idx_b),
		.res    (res)
	);

	// table clear sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + ADDR_W'(1);
			if (clr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign we_a  = clearing_q || (wr_ok && !sel);
	assign we_b  = clearing_q || (wr_ok && sel);
	assign waddr = clearing_q ? clr_q : ADDR_W'(taddr);
	assign wdata = clearing_q ? '0 : tword;

	dccdp_wave_ram u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.re    (fire),
		.raddr (idx_a),
		.rdata (rd_a)
	);

	dccdp_wave_ram u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.re    (fire),
		.raddr (idx_b),
		.rdata (rd_b)
	);

	// s1 holds while the output register is full and stalled; no read is issued then
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1 <= res;
		end
	end

	assign out_load = valid_s1 && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {{(OUT_DATA_W - 2*WORD_W - CNT_W - 1){1'b0}},
				res_s1.running, res_s1.count, rd_b, rd_a};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

/* rtl/dccdp_cfg_regs.sv */
module dccdp_cfg_regs
	import dccdp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	reg_index_t reg_idx;
	logic       wr_en;

	assign reg_idx = reg_index_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_STEP_A:       cfg_q.step_a       <= pwdata;
				REG_STEP_B:       cfg_q.step_b       <= pwdata;
				REG_CYCLE_LIMIT:  cfg_q.cycle_limit  <= pwdata[LIMIT_W-1:0];
				REG_LIMIT_ENABLE: cfg_q.limit_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_STEP_A:       prdata = cfg_q.step_a;
			REG_STEP_B:       prdata = cfg_q.step_b;
			REG_CYCLE_LIMIT:  prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, cfg_q.cycle_limit};
			REG_LIMIT_ENABLE: prdata = {{(APB_DATA_W-1){1'b0}}, cfg_q.limit_enable};
			default:          prdata = '0;
		endcase
	end

endmodule

/* rtl/dccdp_wave_ram.sv */
module dccdp_wave_ram
	import dccdp_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [TABLE_DEPTH];
	logic [WORD_W-1:0] rdata_q;

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

/* rtl/dccdp_accum.sv */
module dccdp_accum
	import dccdp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  cfg_t              cfg,
	output logic              fire,
	output logic [ADDR_W-1:0] idx_a,
	output logic [ADDR_W-1:0] idx_b,
	output tick_res_t         res
);

	logic [PHASE_W-1:0] phase_a_q, phase_b_q;
	logic [PHASE_W-1:0] phase_a_nx, phase_b_nx;
	logic [ADDR_W-1:0]  idx_a_q, idx_b_q;
	logic [ADDR_W-1:0]  new_a, new_b;
	logic [CNT_W-1:0]   cnt_q, cnt_nx;
	logic               running_q;
	logic               stop_hit;
	logic               wrap;

	assign fire       = cmd.tick && running_q;
	assign phase_a_nx = phase_a_q + cfg.step_a;
	assign phase_b_nx = phase_b_q + cfg.step_b;
	assign new_a      = phase_a_nx[FRAC_W +: ADDR_W];
	assign new_b      = phase_b_nx[FRAC_W +: ADDR_W];
	assign wrap       = (new_a == '0) || (new_b == '0);
	assign cnt_nx     = wrap ? cnt_q + CNT_W'(1) : cnt_q;
	assign stop_hit   = cfg.limit_enable &&
		(cnt_q == {{(CNT_W-LIMIT_W){1'b0}}, cfg.cycle_limit});

	assign idx_a       = idx_a_q;
	assign idx_b       = idx_b_q;
	assign res.count   = cnt_nx;
	assign res.running = !stop_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_a_q <= '0;
			phase_b_q <= '0;
			idx_a_q   <= '0;
			idx_b_q   <= '0;
			cnt_q     <= '0;
			running_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_a_q <= phase_a_nx;
				phase_b_q <= phase_b_nx;
				idx_a_q   <= new_a;
				idx_b_q   <= new_b;
				cnt_q     <= cnt_nx;
				running_q <= !stop_hit;
			end
			if (cmd.run) begin
				running_q <= 1'b1;
			end
			if (cmd.stop) begin
				running_q <= 1'b0;
			end
			if (cmd.rewind) begin
				idx_a_q <= '0;
				idx_b_q <= '0;
			end
		end
	end

endmodule

/* rtl/dccdp_checker.sv */
module dccdp_checker
	import dccdp_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic [CNT_W-1:0] last_cnt_q;
	logic             seen_q;
	logic [CNT_W-1:0] cur_cnt;

	assign cur_cnt = m_axis_tdata[2*WORD_W +: CNT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			last_cnt_q <= '0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			seen_q     <= 1'b1;
			last_cnt_q <= cur_cnt;
		end
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// a fresh result always traces back to an accepted request, registered through s1 and then the output register
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without matching request");

	// period count advances by at most one between delivered results
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && seen_q |->
			(cur_cnt == last_cnt_q) || (cur_cnt == last_cnt_q + CNT_W'(1)))
		else $error("period count jumped");

endmodule

bind dual_channel_dds_waveform_player dccdp_checker u_dccdp_checker (.*);

/* sim/tb_dual_channel_dds_waveform_player.sv */
module tb_dual_channel_dds_waveform_player;
	import dccdp_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 8;
	localparam int PHASES      = 8;
	localparam int PHASE_LEN   = 140;
	localparam int ZERO_TICKS  = 50;
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [WORD_W-1:0] dac_a;
		logic [WORD_W-1:0] dac_b;
		logic [CNT_W-1:0]  count;
		logic              running;
	} dds_sample_t;

	typedef enum {ROW_PREDICT, ROW_NO_RESULT, ROW_RESULT} row_kind_t;

	typedef struct {
		row_kind_t               kind;
		logic [OP_W-1:0]         op;
		logic                    sel;
		logic [FIELD_ADDR_W-1:0] addr;
		logic [WORD_W-1:0]       word;
		dds_sample_t             res;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [IN_USER_W-1:0]  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// player state as seen from outside
	bit [PHASE_W-1:0] ph_a, ph_b;
	bit [ADDR_W-1:0]  idx_a, idx_b;
	bit [WORD_W-1:0]  wave_a [TABLE_DEPTH];
	bit [WORD_W-1:0]  wave_b [TABLE_DEPTH];
	bit [CNT_W-1:0]   period_cnt;
	bit               playing;
	bit [PHASE_W-1:0] cfg_step_a, cfg_step_b;
	bit [LIMIT_W-1:0] cfg_limit;
	bit               cfg_limit_en;

	dds_sample_t pending_samples [$];
	stim_row_t   dir_rows [$];

	int  errors, cycles, n_req, n_checked, n_stops, n_wraps, n_writes;
	bit  idle_on;
	int  gap_long_max;
	bit  hold_req;

	dual_channel_dds_waveform_player u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("status: fail");
			$finish;
		end
	end

	function automatic int draw_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(4, gap_long_max);
	endfunction

	// one player step: returns 1 when the request yields a DAC sample
	function automatic bit dds_predict(input logic [OP_W-1:0] op, input logic sel,
			input logic [FIELD_ADDR_W-1:0] addr, input logic [WORD_W-1:0] word,
			output dds_sample_t s);
		bit [ADDR_W-1:0] na, nb;
		s = '0;
		case (op)
			OP_TICK: ;
			OP_WRITE: begin
				n_writes++;
				if (sel)
					wave_b[addr] = word;
				else
					wave_a[addr] = word;
				return 0;
			end
			OP_RUN: begin
				playing = 1'b1;
				return 0;
			end
			OP_STOP: begin
				playing = 1'b0;
				return 0;
			end
			OP_REWIND: begin
				idx_a = '0;
				idx_b = '0;
				return 0;
			end
			default: return 0;
		endcase
		if (!playing)
			return 0;
		// limit compares against the count from before this tick
		if (cfg_limit_en && period_cnt == cfg_limit) begin
			playing = 1'b0;
			n_stops++;
		end
		ph_a = ph_a + cfg_step_a;
		ph_b = ph_b + cfg_step_b;
		na = ph_a[FRAC_W +: ADDR_W];
		nb = ph_b[FRAC_W +: ADDR_W];
		if (na == 0 || nb == 0) begin
			period_cnt++;
			if (period_cnt == 0)
				n_wraps++;
		end
		s.dac_a = wave_a[idx_a];
		s.dac_b = wave_b[idx_b];
		s.count = period_cnt;
		s.running = playing;
		idx_a = na;
		idx_b = nb;
		return 1;
	endfunction

	function automatic void add_row(input row_kind_t kind, input logic [OP_W-1:0] op,
			input logic sel, input logic [FIELD_ADDR_W-1:0] addr,
			input logic [WORD_W-1:0] word, input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b, input logic [CNT_W-1:0] cnt, input logic run);
		stim_row_t row;
		row.kind = kind;
		row.op = op;
		row.sel = sel;
		row.addr = addr;
		row.word = word;
		row.res.dac_a = a;
		row.res.dac_b = b;
		row.res.count = cnt;
		row.res.running = run;
		dir_rows.push_back(row);
	endfunction

	function automatic logic [PHASE_W-1:0] pick_step();
		logic [4:0] m;
		m = 5'($urandom_range(1, 31));
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 32'h0001_0000;
			3: return $urandom;
			4: return $urandom_range(1, 32'h0003_FFFF);
			default: return {m, 27'd0};
		endcase
	endfunction

	function automatic logic [LIMIT_W-1:0] pick_limit();
		if (period_cnt < 250)
			return LIMIT_W'(period_cnt + $urandom_range(1, 6));
		return LIMIT_W'($urandom_range(0, 255));
	endfunction

	task automatic reg_access(input reg_index_t r, input logic [APB_DATA_W-1:0] v);
		logic [APB_DATA_W-1:0] want;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (r)
			REG_STEP_A: begin
				cfg_step_a = v;
				want = v;
			end
			REG_STEP_B: begin
				cfg_step_b = v;
				want = v;
			end
			REG_CYCLE_LIMIT: begin
				cfg_limit = v[LIMIT_W-1:0];
				want = {{(APB_DATA_W-LIMIT_W){1'b0}}, v[LIMIT_W-1:0]};
			end
			default: begin
				cfg_limit_en = v[0];
				want = {{(APB_DATA_W-1){1'b0}}, v[0]};
			end
		endcase
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$display("%0t: readback of register %s expected %h got %h",
				$time, r.name(), want, prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input logic [PHASE_W-1:0] sa, input logic [PHASE_W-1:0] sb,
			input logic [LIMIT_W-1:0] lim, input logic en);
		reg_access(REG_STEP_A, sa);
		reg_access(REG_STEP_B, sb);
		reg_access(REG_CYCLE_LIMIT, {{(APB_DATA_W-LIMIT_W){1'b0}}, lim});
		reg_access(REG_LIMIT_ENABLE, {{(APB_DATA_W-1){1'b0}}, en});
	endtask

	task automatic send_item(input logic [OP_W-1:0] op, input logic sel,
			input logic [FIELD_ADDR_W-1:0] addr, input logic [WORD_W-1:0] word,
			input row_kind_t kind, input dds_sample_t want);
		int gap;
		bit got;
		dds_sample_t s;
		gap = draw_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_DATA_W-FIELD_ADDR_W-WORD_W){1'b0}}, word, addr};
		s_axis_tuser <= {sel, op};
		do @(posedge clk); while (!s_axis_tready);
		n_req++;
		got = dds_predict(op, sel, addr, word, s);
		if (kind == ROW_RESULT)
			pending_samples.push_back(want);
		else if (kind == ROW_PREDICT && got)
			pending_samples.push_back(s);
	endtask

	task automatic rand_request();
		logic [OP_W-1:0]         op;
		logic                    sel;
		logic [FIELD_ADDR_W-1:0] addr;
		logic [WORD_W-1:0]       word;
		int                      r;
		sel = 1'($urandom_range(0, 1));
		addr = FIELD_ADDR_W'($urandom);
		word = WORD_W'($urandom);
		r = $urandom_range(0, 99);
		if (!playing && r < 60) begin
			op = OP_RUN;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 55)
				op = OP_TICK;
			else if (r < 80)
				op = OP_WRITE;
			else if (r < 87)
				op = OP_RUN;
			else if (r < 92)
				op = OP_STOP;
			else if (r < 96)
				op = OP_REWIND;
			else
				op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		end
		// aim writes at entries the next ticks will read
		r = $urandom_range(0, 9);
		if (r < 5)
			addr = FIELD_ADDR_W'((sel ? idx_b : idx_a) + $urandom_range(0, 3));
		else if (r == 5)
			addr = '0;
		else if (r == 6)
			addr = '1;
		r = $urandom_range(0, 9);
		if (r == 0)
			word = '0;
		else if (r == 1)
			word = '1;
		send_item(op, sel, addr, word, ROW_PREDICT, '0);
	endtask

	task automatic wait_drained();
		if (s_axis_tvalid) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic report(input string what, input logic [CNT_W-1:0] e,
			input logic [CNT_W-1:0] a);
		$display("%0t: %s expected %h got %h", $time, what, e, a);
		errors++;
	endtask

	always @(posedge clk) begin : sample_check
		dds_sample_t want, seen;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.dac_a = m_axis_tdata[WORD_W-1:0];
			seen.dac_b = m_axis_tdata[2*WORD_W-1:WORD_W];
			seen.count = m_axis_tdata[2*WORD_W +: CNT_W];
			seen.running = m_axis_tdata[2*WORD_W+CNT_W];
			if (pending_samples.size() == 0) begin
				$display("%0t: unexpected sample, expected none got %h", $time, seen);
				errors++;
			end else begin
				want = pending_samples.pop_front();
				n_checked++;
				if (seen.dac_a !== want.dac_a)
					report("dac_a_word", want.dac_a, seen.dac_a);
				if (seen.dac_b !== want.dac_b)
					report("dac_b_word", want.dac_b, seen.dac_b);
				if (seen.count !== want.count)
					report("period_count", want.count, seen.count);
				if (seen.running !== want.running)
					report("still_running", want.running, seen.running);
			end
		end
	end

	always begin : rx_pace
		int len;
		@(negedge clk);
		len = draw_gap();
		if (hold_req) begin
			hold_req = 1'b0;
			len = LONG_HOLD;
		end
		if (len > 0) begin
			m_axis_tready <= 1'b0;
			repeat (len) @(negedge clk);
		end
		m_axis_tready <= 1'b1;
	end

	initial begin : stimulus
		int p, k;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b1;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_on = 1'b1;
		gap_long_max = 40;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// A advances one entry per tick, B stays on entry 0 so the count rises every tick
		configure(32'h0001_0000, 32'h0000_0000, 8'd2, 1'b1);
		add_row(ROW_NO_RESULT, OP_TICK,  0, 0,    0,       0, 0, 0, 0);
		add_row(ROW_NO_RESULT, OP_WRITE, 0, 0,    16'hFFFF, 0, 0, 0, 0);
		add_row(ROW_NO_RESULT, OP_WRITE, 1, 0,    16'hA5A5, 0, 0, 0, 0);
		add_row(ROW_NO_RESULT, OP_WRITE, 0, 2047, 16'h0001, 0, 0, 0, 0);
		add_row(ROW_NO_RESULT, OP_WRITE, 1, 2047, 16'hFFFF, 0, 0, 0, 0);
		add_row(ROW_NO_RESULT, OP_WRITE, 0, 1,    16'h1234, 0, 0, 0, 0);
		add_row(ROW_NO_RESULT, OP_RUN,   0, 0,    0,       0, 0, 0, 0);
		add_row(ROW_NO_RESULT, OP_RUN,   0, 0,    0,       0, 0, 0, 0);
		add_row(ROW_RESULT,    OP_TICK,  0, 0,    0,       16'hFFFF, 16'hA5A5, 1, 1);
		add_row(ROW_RESULT,    OP_TICK,  0, 0,    0,       16'h1234, 16'hA5A5, 2, 1);
		add_row(ROW_NO_RESULT, OP_REWIND, 0, 0,   0,       0, 0, 0, 0);
		add_row(ROW_RESULT,    OP_TICK,  0, 0,    0,       16'hFFFF, 16'hA5A5, 3, 0);
		add_row(ROW_NO_RESULT, OP_TICK,  0, 0,    0,       0, 0, 0, 0);
		add_row(ROW_NO_RESULT, OP_STOP,  0, 0,    0,       0, 0, 0, 0);
		add_row(ROW_NO_RESULT, OP_RUN,   0, 0,    0,       0, 0, 0, 0);
		add_row(ROW_NO_RESULT, OP_STOP,  0, 0,    0,       0, 0, 0, 0);
		add_row(ROW_NO_RESULT, OP_TICK,  0, 0,    0,       0, 0, 0, 0);
		add_row(ROW_NO_RESULT, OP_SPARE_FIRST, 1, 2047, 16'hFFFF, 0, 0, 0, 0);
		add_row(ROW_NO_RESULT, OP_SPARE_LAST,  1, 2047, 16'hFFFF, 0, 0, 0, 0);
		add_row(ROW_NO_RESULT, OP_RUN,   0, 0,    0,       0, 0, 0, 0);
		add_row(ROW_PREDICT,   OP_TICK,  0, 0,    0,       0, 0, 0, 0);
		add_row(ROW_NO_RESULT, OP_WRITE, 1, 0,    16'h0000, 0, 0, 0, 0);
		add_row(ROW_NO_RESULT, OP_WRITE, 0, 4,    16'hFFFF, 0, 0, 0, 0);
		add_row(ROW_RESULT,    OP_TICK,  0, 0,    0,       16'hFFFF, 16'h0000, 5, 1);
		foreach (dir_rows[k])
			send_item(dir_rows[k].op, dir_rows[k].sel, dir_rows[k].addr,
				dir_rows[k].word, dir_rows[k].kind, dir_rows[k].res);
		wait_drained();

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: configure('1, '0, 8'd0, 1'b1);
				1: configure('0, '1, 8'd255, 1'b1);
				2: configure(pick_step(), pick_step(), pick_limit(), 1'b0);
				default: configure(pick_step(), pick_step(), pick_limit(), $urandom_range(0, 1));
			endcase
			idle_on = (p % 3) != 1;
			for (k = 0; k < PHASE_LEN; k++) begin
				// long sink stall while requests keep coming
				if (p == 2 && k == 40) begin
					send_item(OP_RUN, 0, 0, 0, ROW_PREDICT, '0);
					hold_req = 1'b1;
				end
				if (p == 3 && k == 75)
					wait_drained();
				rand_request();
			end
			wait_drained();
		end

		// the A step only moves phase bits above the table index, so A stays on its entry on every tick
		configure(32'h0800_0000, pick_step(), 8'd255, 1'b0);
		idle_on = 1'b1;
		gap_long_max = 6;
		send_item(OP_RUN, 0, 0, 0, ROW_PREDICT, '0);
		repeat (ZERO_TICKS) send_item(OP_TICK, 0, 0, 0, ROW_PREDICT, '0);
		wait_drained();

		gap_long_max = 40;
		configure(pick_step(), pick_step(), 8'd0, 1'b1);
		for (k = 0; k < PHASE_LEN; k++)
			rand_request();
		wait_drained();

		$display("requests %0d, samples checked %0d, table writes %0d",
			n_req, n_checked, n_writes);
		$display("limit stops %0d, counter wraps %0d, register phases %0d",
			n_stops, n_wraps, PHASES + 3);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
